>>> hw/rtl/bab_pkg.sv
// Package for the block allocation bitmap: payload structs, command codes,
// controller/datapath interface structs and fixed field widths.
// No dependencies.
package bab_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int WORD_BITS      = 32;
    localparam int WORD_SHIFT     = 5;
    localparam int CMD_W          = 2;
    localparam int INDEX_W        = 10;
    localparam int COUNT_W        = 11;
    localparam int SCAN_W         = COUNT_W - WORD_SHIFT + 1;
    localparam int POP_W          = WORD_SHIFT + 1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = COUNT_W'(1024);

    typedef enum logic [CMD_W-1:0] {
        CMD_USE   = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_CLEAR = 2'd3
    } command_t;

    typedef struct packed {
        command_t           command;
        logic [INDEX_W-1:0] block_index;
    } in_beat_t;

    typedef struct packed {
        logic               block_used;
        logic               index_valid;
        logic [COUNT_W-1:0] free_count;
        logic [INDEX_W-1:0] first_free;
        logic               none_free;
    } out_beat_t;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic rd_target;
        logic wr_target;
        logic scan_run;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_clear;
        logic in_mark;
        logic clr_last;
        logic scan_done;
        logic out_free;
    } ctrl_status_t;

endpackage

>>> hw/rtl/block_allocation_bitmap.sv
// Block allocation bitmap top level: controller and datapath.
// Depends on bab_pkg, bab_ctrl, bab_dp (and bab_ram through bab_dp).
//
// Keeps a used/free bit per block in a RAM of 32-bit words. One command per
// beat (mark used, mark free, test, clear all); each returns one result beat
// with the block state, index validity, free count and lowest free block.
// Every command ends with a scan over the ceil(N/32) words that hold the first
// N blocks, with N the block count capped at MAX_BLOCKS; the scan reads one
// RAM word per cycle. A valid mark first does a read-modify-write of its word.
// Clear all first writes zeros to all ceil(MAX_BLOCKS/32) words. After reset
// the same sweep runs before in_ready rises; the count register can be written
// meanwhile. The next command is accepted while a result waits in the output
// register.
module block_allocation_bitmap
    import bab_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_beat_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_beat_t          out_data,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    bab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bab_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

>>> hw/rtl/bab_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module bab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/bab_ctrl.sv
// Controller state machine of the block allocation bitmap.
// Depends on bab_pkg for the command and status structs.
module bab_ctrl
    import bab_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CLEAR = 7'b0000100,
        S_RD    = 7'b0001000,
        S_MOD   = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (status.in_clear)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (status.in_mark)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_RD:
            begin
                cmd.rd_target = 1'b1;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                cmd.wr_target = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

>>> hw/rtl/bab_dp.sv
// Datapath of the block allocation bitmap: count register, bitmap RAM,
// word scanner with free count and first-free search, output register.
// Depends on bab_pkg and bab_ram.
module bab_dp
    import bab_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output ctrl_status_t       status,
    input  in_beat_t           in_data,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_beat_t          out_data
);

    localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [COUNT_W-1:0]   block_count_reg;
    logic [COUNT_W-1:0]   limit_cur;
    logic                 in_valid_idx;

    command_t             cmd_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [COUNT_W-1:0]   limit_reg;
    logic                 valid_reg;

    logic [AW-1:0]        clr_addr_reg;
    logic [SCAN_W-1:0]    rd_word_reg;
    logic                 proc_valid_reg;
    logic [SCAN_W-1:0]    proc_word_reg;
    logic [SCAN_W-1:0]    nwords;

    logic [COUNT_W-1:0]   acc_free_reg;
    logic                 found_reg;
    logic [COUNT_W-1:0]   lowest_reg;
    logic                 used_bit_reg;

    logic                 out_valid_reg;
    out_beat_t            out_data_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [AW-1:0]        tgt_addr;
    logic [WORD_BITS-1:0] mod_word;

    logic [COUNT_W:0]     base;
    logic [COUNT_W:0]     remain;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [POP_W-1:0]     pop;
    logic [WORD_SHIFT-1:0] tz;
    logic                 issue;

    // count register; its value is saturated against capacity in limit_cur
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            block_count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (32'(block_count_reg) > MAX_BLOCKS)
        begin
            limit_cur = COUNT_W'(MAX_BLOCKS);
        end
        else
        begin
            limit_cur = block_count_reg;
        end
        in_valid_idx = COUNT_W'(in_data.block_index) < limit_cur;
    end

    assign status.in_clear = (in_data.command == CMD_CLEAR);
    assign status.in_mark  = in_valid_idx &&
                             (in_data.command == CMD_USE || in_data.command == CMD_FREE);

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg   <= in_data.command;
            idx_reg   <= in_data.block_index;
            limit_reg <= limit_cur;
            valid_reg <= in_valid_idx;
        end
    end

    // clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign status.clr_last = (clr_addr_reg == AW'(WORDS - 1));

    // RAM ports
    assign tgt_addr = AW'(idx_reg[INDEX_W-1:WORD_SHIFT]);

    always_comb
    begin
        mod_word = ram_rdata;
        mod_word[idx_reg[WORD_SHIFT-1:0]] = (cmd_reg == CMD_USE);
    end

    assign ram_we    = cmd.clr_step | cmd.wr_target;
    assign ram_waddr = cmd.clr_step ? clr_addr_reg : tgt_addr;
    assign ram_wdata = cmd.clr_step ? '0 : mod_word;
    assign ram_raddr = cmd.rd_target ? tgt_addr : AW'(rd_word_reg);

    bab_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan: one word read per cycle, processed when its data returns
    assign nwords = SCAN_W'((12'(limit_reg) + 12'(WORD_BITS - 1)) >> WORD_SHIFT);
    assign issue  = cmd.scan_run && (rd_word_reg != nwords);
    assign status.scan_done = (rd_word_reg == nwords) && !proc_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_word_reg    <= '0;
            proc_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            acc_free_reg   <= '0;
        end
        else if (cmd.load_item)
        begin
            rd_word_reg    <= '0;
            proc_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            acc_free_reg   <= '0;
        end
        else
        begin
            proc_valid_reg <= issue;
            if (issue)
            begin
                rd_word_reg <= rd_word_reg + SCAN_W'(1);
            end
            if (proc_valid_reg)
            begin
                acc_free_reg <= acc_free_reg + COUNT_W'(pop);
                if (!found_reg && (free_bits != '0))
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_word_reg <= rd_word_reg;
        if (proc_valid_reg)
        begin
            if (!found_reg && (free_bits != '0))
            begin
                lowest_reg <= COUNT_W'(base + (COUNT_W + 1)'(tz));
            end
            if (proc_word_reg == SCAN_W'(idx_reg[INDEX_W-1:WORD_SHIFT]))
            begin
                used_bit_reg <= ram_rdata[idx_reg[WORD_SHIFT-1:0]];
            end
        end
    end

    always_comb
    begin
        base   = {proc_word_reg, {WORD_SHIFT{1'b0}}};
        remain = (COUNT_W + 1)'(limit_reg) - base;
        if (remain >= (COUNT_W + 1)'(WORD_BITS))
        begin
            word_mask = '1;
        end
        else
        begin
            word_mask = (WORD_BITS'(1) << remain[WORD_SHIFT-1:0]) - WORD_BITS'(1);
        end
        free_bits = ~ram_rdata & word_mask;
        pop = '0;
        tz  = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            pop = pop + POP_W'(free_bits[i]);
        end
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                tz = WORD_SHIFT'(i);
            end
        end
    end

    // output register
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.block_used  <= valid_reg & used_bit_reg;
            out_data_reg.index_valid <= valid_reg;
            out_data_reg.free_count  <= acc_free_reg;
            out_data_reg.first_free  <= found_reg ? lowest_reg[INDEX_W-1:0] : '0;
            out_data_reg.none_free   <= !found_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
